@@ sv/clpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpr_pkg: shared types and constants of the parameter ramp
// widths, command and register codes, divider handshake structs, clamp helper
// ----------------------------------------------------------------------------
package clpr_pkg;

    localparam int unsigned W_VAL  = 32;
    localparam int unsigned W_ACC  = 49;
    localparam int unsigned W_DVD  = 48;
    localparam int unsigned W_DVS  = 32;
    localparam int unsigned W_CNT  = 6;
    localparam int unsigned W_CMD  = 3;
    localparam int unsigned W_TICK = 11;
    localparam int unsigned W_RAMP = 20;
    localparam int unsigned W_IDX  = 2;

    // commands
    localparam logic [W_CMD-1:0] CMD_TICK = 3'd0;
    localparam logic [W_CMD-1:0] CMD_TGT  = 3'd1;
    localparam logic [W_CMD-1:0] CMD_NOW  = 3'd2;
    localparam logic [W_CMD-1:0] CMD_ADD  = 3'd3;
    localparam logic [W_CMD-1:0] CMD_SUB  = 3'd4;
    localparam logic [W_CMD-1:0] CMD_MUL  = 3'd5;
    localparam logic [W_CMD-1:0] CMD_DIV  = 3'd6;

    // register indexes
    localparam logic [W_IDX-1:0] REG_MIN    = 2'd0;
    localparam logic [W_IDX-1:0] REG_MAX    = 2'd1;
    localparam logic [W_IDX-1:0] REG_RAMP   = 2'd2;
    localparam logic [W_IDX-1:0] REG_NOTIFY = 2'd3;

    // reset values
    localparam logic signed [W_VAL-1:0] RST_MIN  = 32'sh0000_0000;
    localparam logic signed [W_VAL-1:0] RST_MAX  = 32'sh7FFF_FFFF;
    localparam logic [W_RAMP-1:0]       RST_RAMP = 20'd4410;

    localparam int DEF_MAX_TICK_BATCH = 1024;

    // divider step counts: full 48 bit dividend, or a 33 bit one preshifted
    localparam logic [W_CNT-1:0] STEPS_DIV    = 6'd48;
    localparam logic [W_CNT-1:0] STEPS_TGT    = 6'd33;
    localparam int unsigned      TGT_PRESHIFT = 15;

    typedef struct packed {
        logic             start;
        logic [W_DVD-1:0] dividend;
        logic [W_DVS-1:0] divisor;
        logic [W_CNT-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [W_DVD-1:0] quotient;
    } t_div_sts;

    // limit to hi first, then raise to lo
    function automatic logic signed [W_VAL-1:0] clamp(
        input logic signed [W_ACC-1:0] x,
        input logic signed [W_VAL-1:0] lo,
        input logic signed [W_VAL-1:0] hi
    );
        logic signed [W_ACC-1:0] y;
        logic signed [W_ACC-1:0] lo_x;
        logic signed [W_ACC-1:0] hi_x;
        lo_x = $signed({{(W_ACC-W_VAL){lo[W_VAL-1]}}, lo});
        hi_x = $signed({{(W_ACC-W_VAL){hi[W_VAL-1]}}, hi});
        y = x;
        if (y > hi_x) y = hi_x;
        if (y < lo_x) y = lo_x;
        return y[W_VAL-1:0];
    endfunction

endpackage

@@ sv/clpr_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpr_ifs: channel interfaces of the parameter ramp
// command words in, result words out, register writes
// ----------------------------------------------------------------------------
interface clpr_in_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               cmd;
    logic signed [31:0]       operand;
    logic [10:0]              tick_count;
    modport source(output valid, cmd, operand, tick_count, input ready);
    modport sink(input valid, cmd, operand, tick_count, output ready);
endinterface

interface clpr_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       value_now;
    logic signed [31:0]       target_now;
    logic                     notify;
    logic                     ramping;
    logic                     error;
    modport source(output valid, value_now, target_now, notify, ramping, error,
                   input ready);
    modport sink(input valid, value_now, target_now, notify, ramping, error,
                 output ready);
endinterface

interface clpr_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               index;
    logic [31:0]              data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ sv/clpr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpr_div: restoring unsigned divider, one quotient bit per cycle
// quotient stays on o_sts.quotient after done until the next start
// ----------------------------------------------------------------------------
module clpr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clpr_pkg::t_div_ctl  i_ctl,
    output clpr_pkg::t_div_sts  o_sts
);

    logic                          r_busy;
    logic                          r_done;
    logic [clpr_pkg::W_CNT-1:0]    r_cnt;
    logic [clpr_pkg::W_DVD-1:0]    r_dvd;
    logic [clpr_pkg::W_DVS-1:0]    r_rem;
    logic [clpr_pkg::W_DVS-1:0]    r_dvs;

    logic [clpr_pkg::W_DVS:0]      w_trial;
    logic [clpr_pkg::W_DVS:0]      w_sub;
    logic                          w_ge;

    assign w_trial = {r_rem, r_dvd[clpr_pkg::W_DVD-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == clpr_pkg::W_CNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= i_ctl.dividend;
            r_dvs <= i_ctl.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[clpr_pkg::W_DVS-1:0] : w_trial[clpr_pkg::W_DVS-1:0];
            r_dvd <= {r_dvd[clpr_pkg::W_DVD-2:0], w_ge};
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_dvd;

endmodule

@@ sv/clamped_linear_parameter_ramp.sv @@
`timescale 1ns / 1ps
// path from accept to result valid: a divide by zero and the unused code go
// from prep straight to output; set-now, add and subtract pass prep and fin;
// tick and multiply pass prep, adjust and fin; set-target and divide wait on
// the shared divider, one quotient bit a cycle (33 and 48 bits)
// one word at a time, next accepted after result taken
// reset: synchronous active low, state cleared to zero, registers to defaults
// ----------------------------------------------------------------------------
// clamped_linear_parameter_ramp: Q16.16 control parameter smoother
// set-target computes a per-sample step, ticks walk the value to the target,
// immediate commands set, add, subtract, multiply or divide the value
// ----------------------------------------------------------------------------
module clamped_linear_parameter_ramp #(
    parameter int MAX_TICK_BATCH = clpr_pkg::DEF_MAX_TICK_BATCH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clpr_in_if.sink     i_cmd,
    clpr_out_if.source  o_res,
    clpr_cfg_if.sink    i_cfg
);

    localparam int unsigned VW = clpr_pkg::W_VAL;
    localparam int unsigned AW = clpr_pkg::W_ACC;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_ADJ  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic signed [VW-1:0]               r_min;
    logic signed [VW-1:0]               r_max;
    logic [clpr_pkg::W_RAMP-1:0]        r_ramp;
    logic                               r_nen;

    // smoother state
    logic signed [VW-1:0] r_cur, n_cur;
    logic signed [VW-1:0] r_tgt, n_tgt;
    logic signed [VW-1:0] r_step, n_step;
    logic                 r_notify, n_notify;
    logic                 r_err, n_err;

    // latched word and scratch
    logic [clpr_pkg::W_CMD-1:0]   r_cmd;
    logic signed [VW-1:0]         r_opnd;
    logic [clpr_pkg::W_TICK-1:0]  r_n;
    logic signed [2*VW-1:0]       r_prod;
    logic signed [AW-1:0]         r_acc;
    logic                         r_neg;
    logic                         r_dnz;
    logic                         r_move;

    logic                         w_in_acc;
    logic [clpr_pkg::W_TICK-1:0]  w_n_eff;
    logic signed [VW-1:0]         w_mul_a;
    logic signed [VW-1:0]         w_mul_b;
    logic signed [AW-1:0]         w_cur_x;
    logic signed [AW-1:0]         w_tgt_x;
    logic signed [AW-1:0]         w_opnd_x;
    logic signed [AW-1:0]         w_mtrunc;
    logic [VW-1:0]                w_cur_mag;
    logic [VW-1:0]                w_opnd_mag;
    logic signed [VW:0]           w_tdiff;
    logic [VW:0]                  w_tdiff_mag;
    logic [clpr_pkg::W_RAMP-1:0]  w_len;
    logic signed [AW-1:0]         w_qdiv;
    logic signed [VW+1:0]         w_qtgt;
    logic signed [VW+1:0]         w_qtgt_fix;
    logic signed [VW-1:0]         w_step_sat;
    logic signed [VW-1:0]         w_tick_val;

    clpr_pkg::t_div_ctl w_div_ctl;
    clpr_pkg::t_div_sts w_div_sts;

    clpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_sts   (w_div_sts)
    );

    // handshakes
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // tick length limited to the batch size
    assign w_n_eff = ({21'd0, i_cmd.tick_count} > 32'(MAX_TICK_BATCH))
                   ? clpr_pkg::W_TICK'(MAX_TICK_BATCH) : i_cmd.tick_count;

    // sign extensions to the accumulator width
    assign w_cur_x  = $signed({{(AW-VW){r_cur[VW-1]}}, r_cur});
    assign w_tgt_x  = $signed({{(AW-VW){r_tgt[VW-1]}}, r_tgt});
    assign w_opnd_x = $signed({{(AW-VW){r_opnd[VW-1]}}, r_opnd});

    // shared multiplier: step times tick count, or value times operand
    assign w_mul_a = (r_cmd == clpr_pkg::CMD_TICK) ? r_step : r_cur;
    assign w_mul_b = (r_cmd == clpr_pkg::CMD_TICK)
                   ? $signed({{(VW-clpr_pkg::W_TICK){1'b0}}, r_n}) : r_opnd;

    // product over 65536, truncated toward zero
    assign w_mtrunc = $signed({r_prod[2*VW-1], r_prod[2*VW-1:16]})
                    + $signed({{(AW-1){1'b0}},
                               (r_prod[2*VW-1] && (r_prod[15:0] != 16'd0))});

    // magnitudes for the divider
    assign w_cur_mag  = r_cur[VW-1]  ? VW'(-r_cur)  : r_cur;
    assign w_opnd_mag = r_opnd[VW-1] ? VW'(-r_opnd) : r_opnd;

    // set-target distance, clamped target sits in r_acc
    assign w_tdiff     = $signed({r_acc[VW-1], r_acc[VW-1:0]})
                       - $signed({r_cur[VW-1], r_cur});
    assign w_tdiff_mag = w_tdiff[VW] ? (VW+1)'(-w_tdiff) : w_tdiff;
    assign w_len       = (r_ramp == '0) ? clpr_pkg::W_RAMP'(1) : r_ramp;

    // signed quotients
    assign w_qdiv = r_neg ? -$signed({1'b0, w_div_sts.quotient})
                          :  $signed({1'b0, w_div_sts.quotient});
    assign w_qtgt = r_neg ? -$signed({1'b0, w_div_sts.quotient[VW:0]})
                          :  $signed({1'b0, w_div_sts.quotient[VW:0]});

    // tiny step becomes one lsb toward the target, then saturate
    always_comb begin
        w_qtgt_fix = w_qtgt;
        if (w_qtgt == '0 && r_dnz) begin
            w_qtgt_fix = r_neg ? -(VW+2)'(1) : (VW+2)'(1);
        end
        if (w_qtgt_fix > $signed({2'b00, clpr_pkg::RST_MAX})) begin
            w_step_sat = $signed({1'b0, {(VW-1){1'b1}}});
        end else if (w_qtgt_fix < $signed({2'b11, 1'b1, {(VW-1){1'b0}}})) begin
            w_step_sat = $signed({1'b1, {(VW-1){1'b0}}});
        end else begin
            w_step_sat = w_qtgt_fix[VW-1:0];
        end
    end

    // a tick that would pass the target stops on it
    always_comb begin
        w_tick_val = r_acc[VW-1:0];
        if (!r_step[VW-1] && r_acc > w_tgt_x) begin
            w_tick_val = r_tgt;
        end
        if (r_step[VW-1] && r_acc < w_tgt_x) begin
            w_tick_val = r_tgt;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_step    = r_step;
        n_notify  = r_notify;
        n_err     = r_err;
        w_div_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state  = S_PREP;
                    n_notify = 1'b0;
                    n_err    = 1'b0;
                end
            end
            S_PREP: begin
                case (r_cmd) inside
                    clpr_pkg::CMD_TICK, clpr_pkg::CMD_MUL, clpr_pkg::CMD_TGT: begin
                        n_state = S_ADJ;
                    end
                    clpr_pkg::CMD_NOW, clpr_pkg::CMD_ADD, clpr_pkg::CMD_SUB: begin
                        n_state = S_FIN;
                    end
                    clpr_pkg::CMD_DIV: begin
                        if (r_opnd == '0) begin
                            // divide by zero: flag it, touch nothing
                            n_err   = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            w_div_ctl.start    = 1'b1;
                            w_div_ctl.dividend = {w_cur_mag, 16'd0};
                            w_div_ctl.divisor  = w_opnd_mag;
                            w_div_ctl.steps    = clpr_pkg::STEPS_DIV;
                            n_state            = S_DIV;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_ADJ: begin
                if (r_cmd == clpr_pkg::CMD_TGT) begin
                    // 33 bit distance preshifted to the top of the dividend
                    w_div_ctl.start    = 1'b1;
                    w_div_ctl.dividend = {w_tdiff_mag, {clpr_pkg::TGT_PRESHIFT{1'b0}}};
                    w_div_ctl.divisor  = {{(clpr_pkg::W_DVS-clpr_pkg::W_RAMP){1'b0}}, w_len};
                    w_div_ctl.steps    = clpr_pkg::STEPS_TGT;
                    n_state            = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
                case (r_cmd) inside
                    clpr_pkg::CMD_TICK: begin
                        if (r_move) begin
                            n_cur    = w_tick_val;
                            n_notify = r_nen;
                        end
                    end
                    clpr_pkg::CMD_TGT: begin
                        n_tgt  = r_acc[VW-1:0];
                        n_step = w_step_sat;
                    end
                    clpr_pkg::CMD_NOW, clpr_pkg::CMD_ADD, clpr_pkg::CMD_SUB,
                    clpr_pkg::CMD_MUL: begin
                        n_cur    = clpr_pkg::clamp(r_acc, r_min, r_max);
                        n_tgt    = n_cur;
                        n_step   = '0;
                        n_notify = r_nen;
                    end
                    clpr_pkg::CMD_DIV: begin
                        n_cur    = clpr_pkg::clamp(w_qdiv, r_min, r_max);
                        n_tgt    = n_cur;
                        n_step   = '0;
                        n_notify = r_nen;
                    end
                    default: begin
                    end
                endcase
            end
            S_OUT: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control, configuration and smoother state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min    <= clpr_pkg::RST_MIN;
            r_max    <= clpr_pkg::RST_MAX;
            r_ramp   <= clpr_pkg::RST_RAMP;
            r_nen    <= 1'b0;
            r_cur    <= '0;
            r_tgt    <= '0;
            r_step   <= '0;
            r_notify <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_tgt    <= n_tgt;
            r_step   <= n_step;
            r_notify <= n_notify;
            r_err    <= n_err;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    clpr_pkg::REG_MIN:    r_min  <= $signed(i_cfg.data);
                    clpr_pkg::REG_MAX:    r_max  <= $signed(i_cfg.data);
                    clpr_pkg::REG_RAMP:   r_ramp <= i_cfg.data[clpr_pkg::W_RAMP-1:0];
                    clpr_pkg::REG_NOTIFY: r_nen  <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // input latch and scratch datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cmd  <= i_cmd.cmd;
                    r_opnd <= i_cmd.operand;
                    r_n    <= w_n_eff;
                end
            end
            S_PREP: begin
                r_prod <= w_mul_a * w_mul_b;
                // tick moves only when the step points at the target
                r_move <= (r_n != '0)
                       && ((!r_step[VW-1] && r_step != '0 && r_cur < r_tgt)
                        || (r_step[VW-1] && r_cur > r_tgt));
                case (r_cmd) inside
                    clpr_pkg::CMD_TGT: begin
                        r_acc <= $signed({{(AW-VW){1'b0}}, clpr_pkg::clamp(w_opnd_x, r_min, r_max)});
                    end
                    clpr_pkg::CMD_NOW: r_acc <= w_opnd_x;
                    clpr_pkg::CMD_ADD: r_acc <= w_cur_x + w_opnd_x;
                    clpr_pkg::CMD_SUB: r_acc <= w_cur_x - w_opnd_x;
                    clpr_pkg::CMD_DIV: r_neg <= r_cur[VW-1] ^ r_opnd[VW-1];
                    default: begin
                    end
                endcase
            end
            S_ADJ: begin
                case (r_cmd) inside
                    clpr_pkg::CMD_TICK: r_acc <= w_cur_x + $signed(r_prod[AW-1:0]);
                    clpr_pkg::CMD_MUL:  r_acc <= w_mtrunc;
                    clpr_pkg::CMD_TGT: begin
                        r_neg <= w_tdiff[VW];
                        r_dnz <= (w_tdiff != '0);
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // result word, held while the sink stalls
    assign o_res.valid      = (r_state == S_OUT);
    assign o_res.value_now  = r_cur;
    assign o_res.target_now = r_tgt;
    assign o_res.notify     = r_notify;
    assign o_res.ramping    = (r_cur != r_tgt);
    assign o_res.error      = r_err;

    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("divider done outside the divide wait");

    // an error is only a divide by zero and never notifies
    a_err_is_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_err) |-> (r_cmd == clpr_pkg::CMD_DIV && !r_notify))
        else $error("error flagged on a non-divide word or with notify");

    // immediate commands leave the value settled on the target
    a_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !r_err
         && (r_cmd == clpr_pkg::CMD_NOW || r_cmd == clpr_pkg::CMD_ADD
          || r_cmd == clpr_pkg::CMD_SUB || r_cmd == clpr_pkg::CMD_MUL
          || r_cmd == clpr_pkg::CMD_DIV))
        |-> (r_cur == r_tgt && r_step == '0))
        else $error("immediate command left a ramp running");

    // a result taken returns the sequencer to idle
    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after the result");

endmodule
